// ----- hdl/shht_pkg.sv -----
// ----------------------------------------------------------------------------
// shht_pkg
// Shared types and codes for the selection handle hit test unit.
// ----------------------------------------------------------------------------
package shht_pkg;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_BOX_VALID   = 3'd0,
        REG_CORNER_0    = 3'd1,
        REG_CORNER_1    = 3'd2,
        REG_CORNER_2    = 3'd3,
        REG_CORNER_3    = 3'd4,
        REG_ANCHOR      = 3'd5,
        REG_HIT_RADIUS  = 3'd6,
        REG_ROTATE_BAND = 3'd7
    } reg_idx_t;

    typedef logic [3:0] handle_kind_t;

    localparam handle_kind_t KIND_NONE   = 4'd0;
    localparam handle_kind_t KIND_ANCHOR = 4'd1;
    localparam handle_kind_t KIND_CORNER = 4'd2;
    localparam handle_kind_t KIND_EDGE   = 4'd6;
    localparam handle_kind_t KIND_ROTATE = 4'd10;

    localparam int NUM_CORNERS = 4;

endpackage

// ----- hdl/selection_handle_hit_test_unit.sv -----
// ----------------------------------------------------------------------------
// selection_handle_hit_test_unit
// Classifies a query point against the loaded selection box: anchor, corner,
// edge midpoint or rotate zone handle, in that priority.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  point     point_valid / point_ready   point_x, point_y
//  result    result_valid / result_ready handle_kind
//  config    APB psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// six register stages: one request enters every cycle while the pipeline is not
// held, and each request is registered in every stage before its result is on
// the outputs; the depth comes from the coordinate multiplies, the split
// squares of the rotate terms and the wide band compares
// the whole pipeline holds while a result waits and result_ready is low
// rst_n clears the valid bits and the configuration registers
// ----------------------------------------------------------------------------
module selection_handle_hit_test_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    output logic        point_ready,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  handle_kind,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NC   = shht_pkg::NUM_CORNERS;
    localparam int CW   = COORD_BITS;
    localparam int DW1  = CW + 1;
    localparam int DW2  = CW + 2;
    localparam int PW   = 2 * DW2 + 1;
    localparam int DOTW = DW1 + DW2 + 1;
    localparam int SQW  = 2 * DOTW;
    localparam int CMPW = (SQW > 32 + PW) ? SQW : 32 + PW;
    localparam int DSW  = (PW > 34) ? PW : 34;
    // halves for the split squares of the rotate terms
    localparam int HB   = (DOTW + 1) / 2;
    localparam int HH   = DOTW - HB;
    localparam int SLW  = 2 * HB;
    localparam int SHW  = 2 * HH;
    // halves of the squared corner distance for the band thresholds
    localparam int LB   = (PW + 1) / 2;
    localparam int LH   = PW - LB;
    localparam int RLW  = 32 + LB;
    localparam int RHW  = 32 + LH;

    // coordinate from a 16-bit field, read as CW-bit two's complement
    function automatic logic signed [CW-1:0] coord(input logic [15:0] f);
        logic [31:0] w;
        w = {16'd0, f};
        return $signed(w[CW-1:0]);
    endfunction

    // configuration registers
    logic        box_valid_reg;
    logic [31:0] corner_reg [NC];
    logic [31:0] anchor_reg;
    logic [15:0] radius_reg;
    logic [31:0] band_reg;
    logic        wr_en;
    shht_pkg::reg_idx_t wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = shht_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
            for (int k = 0; k < NC; k++)
            begin
                corner_reg[k] <= 32'd0;
            end
            anchor_reg <= 32'd0;
            radius_reg <= 16'd0;
            band_reg   <= 32'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                shht_pkg::REG_BOX_VALID:   box_valid_reg <= pwdata[0];
                shht_pkg::REG_CORNER_0:    corner_reg[0] <= pwdata;
                shht_pkg::REG_CORNER_1:    corner_reg[1] <= pwdata;
                shht_pkg::REG_CORNER_2:    corner_reg[2] <= pwdata;
                shht_pkg::REG_CORNER_3:    corner_reg[3] <= pwdata;
                shht_pkg::REG_ANCHOR:      anchor_reg    <= pwdata;
                shht_pkg::REG_HIT_RADIUS:  radius_reg    <= pwdata[15:0];
                shht_pkg::REG_ROTATE_BAND: band_reg      <= pwdata;
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (wr_idx)
            shht_pkg::REG_BOX_VALID:   prdata = {31'd0, box_valid_reg};
            shht_pkg::REG_CORNER_0:    prdata = corner_reg[0];
            shht_pkg::REG_CORNER_1:    prdata = corner_reg[1];
            shht_pkg::REG_CORNER_2:    prdata = corner_reg[2];
            shht_pkg::REG_CORNER_3:    prdata = corner_reg[3];
            shht_pkg::REG_ANCHOR:      prdata = anchor_reg;
            shht_pkg::REG_HIT_RADIUS:  prdata = {16'd0, radius_reg};
            shht_pkg::REG_ROTATE_BAND: prdata = band_reg;
            default:                   prdata = 32'd0;
        endcase
    end

    // coordinates of the box
    logic signed [CW-1:0] cx [NC];
    logic signed [CW-1:0] cy [NC];
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            cx[k] = coord(corner_reg[k][15:0]);
            cy[k] = coord(corner_reg[k][31:16]);
        end
        ax = coord(anchor_reg[15:0]);
        ay = coord(anchor_reg[31:16]);
    end

    // derived box terms, registered from the configuration registers
    logic signed [DW2-1:0] dx_reg [NC];
    logic signed [DW2-1:0] dy_reg [NC];
    logic [NC-1:0]         dz_reg;
    logic [PW-1:0]         len2_reg [NC];
    logic [31:0]           r_sq_reg;
    logic [31:0]           in_sq_reg;
    logic [31:0]           out_sq_reg;
    logic [RLW-1:0]        in_lo_reg [NC];
    logic [RHW-1:0]        in_hi_reg [NC];
    logic [RLW-1:0]        out_lo_reg [NC];
    logic [RHW-1:0]        out_hi_reg [NC];
    logic [RLW-1:0]        r_lo_reg [NC];
    logic [RHW-1:0]        r_hi_reg [NC];
    logic [CMPW-1:0]       in_rhs_reg [NC];
    logic [CMPW-1:0]       out_rhs_reg [NC];
    logic [CMPW-1:0]       r_rhs_reg [NC];
    logic [15:0]           inner;
    logic [15:0]           outer;

    assign inner = band_reg[15:0];
    assign outer = (band_reg[31:16] < inner) ? inner : band_reg[31:16];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NC; k++)
        begin
            dx_reg[k] <= DW2'(cx[k]) + DW2'(cx[k]) - DW2'(cx[0]) - DW2'(cx[2]);
            dy_reg[k] <= DW2'(cy[k]) + DW2'(cy[k]) - DW2'(cy[0]) - DW2'(cy[2]);
            dz_reg[k]   <= (dx_reg[k] == '0) && (dy_reg[k] == '0);
            len2_reg[k] <= PW'(PW'(dx_reg[k]) * PW'(dx_reg[k]))
                         + PW'(PW'(dy_reg[k]) * PW'(dy_reg[k]));
            // thresholds times squared axis length, as two partial products
            in_lo_reg[k]  <= RLW'(in_sq_reg) * RLW'(len2_reg[k][LB-1:0]);
            in_hi_reg[k]  <= RHW'(in_sq_reg) * RHW'(len2_reg[k][PW-1:LB]);
            out_lo_reg[k] <= RLW'(out_sq_reg) * RLW'(len2_reg[k][LB-1:0]);
            out_hi_reg[k] <= RHW'(out_sq_reg) * RHW'(len2_reg[k][PW-1:LB]);
            r_lo_reg[k]   <= RLW'(r_sq_reg) * RLW'(len2_reg[k][LB-1:0]);
            r_hi_reg[k]   <= RHW'(r_sq_reg) * RHW'(len2_reg[k][PW-1:LB]);
            in_rhs_reg[k]  <= (CMPW'(in_hi_reg[k]) << LB) + CMPW'(in_lo_reg[k]);
            out_rhs_reg[k] <= (CMPW'(out_hi_reg[k]) << LB) + CMPW'(out_lo_reg[k]);
            r_rhs_reg[k]   <= (CMPW'(r_hi_reg[k]) << LB) + CMPW'(r_lo_reg[k]);
        end
        r_sq_reg    <= 32'(radius_reg) * 32'(radius_reg);
        in_sq_reg   <= 32'(inner) * 32'(inner);
        out_sq_reg  <= 32'(outer) * 32'(outer);
    end

    // pipeline advance
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    assign en           = !v6_reg || result_ready;
    assign point_ready  = en;
    assign result_valid = v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= point_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // stage 1: capture the point
    logic signed [CW-1:0] px_reg;
    logic signed [CW-1:0] py_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= coord(point_x);
            py_reg <= coord(point_y);
        end
    end

    // stage 2: offsets from anchor, corners and doubled edge midpoints
    logic signed [DW1-1:0] eax_reg, eay_reg;
    logic signed [DW1-1:0] ex_reg [NC];
    logic signed [DW1-1:0] ey_reg [NC];
    logic signed [DW2-1:0] gx_reg [NC];
    logic signed [DW2-1:0] gy_reg [NC];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eax_reg <= DW1'(px_reg) - DW1'(ax);
            eay_reg <= DW1'(py_reg) - DW1'(ay);
            for (int k = 0; k < NC; k++)
            begin
                ex_reg[k] <= DW1'(px_reg) - DW1'(cx[k]);
                ey_reg[k] <= DW1'(py_reg) - DW1'(cy[k]);
                gx_reg[k] <= DW2'(px_reg) + DW2'(px_reg) - DW2'(cx[k])
                           - DW2'(cx[(k + 1) % NC]);
                gy_reg[k] <= DW2'(py_reg) + DW2'(py_reg) - DW2'(cy[k])
                           - DW2'(cy[(k + 1) % NC]);
            end
        end
    end

    // stage 3: squared distances, projection and lateral terms
    logic [PW-1:0]          asq_reg;
    logic [PW-1:0]          csq_reg [NC];
    logic [PW-1:0]          gsq_reg [NC];
    logic signed [DOTW-1:0] dot_reg [NC];
    logic signed [DOTW-1:0] crs_reg [NC];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            asq_reg <= PW'(PW'(eax_reg) * PW'(eax_reg))
                     + PW'(PW'(eay_reg) * PW'(eay_reg));
            for (int k = 0; k < NC; k++)
            begin
                csq_reg[k] <= PW'(PW'(ex_reg[k]) * PW'(ex_reg[k]))
                            + PW'(PW'(ey_reg[k]) * PW'(ey_reg[k]));
                gsq_reg[k] <= PW'(PW'(gx_reg[k]) * PW'(gx_reg[k]))
                            + PW'(PW'(gy_reg[k]) * PW'(gy_reg[k]));
                dot_reg[k] <= DOTW'(DOTW'(ex_reg[k]) * DOTW'(dx_reg[k]))
                            + DOTW'(DOTW'(ey_reg[k]) * DOTW'(dy_reg[k]));
                crs_reg[k] <= DOTW'(DOTW'(ex_reg[k]) * DOTW'(dy_reg[k]))
                            - DOTW'(DOTW'(ey_reg[k]) * DOTW'(dx_reg[k]));
            end
        end
    end

    // stage 4: disc tests and partial squares of the rotate terms
    logic            a_hit_reg;
    logic [NC-1:0]   c_hit_reg;
    logic [NC-1:0]   g_hit_reg;
    logic [NC-1:0]   dneg_reg;
    logic [SLW-1:0]  dlo_reg [NC];
    logic [SHW-1:0]  dhi_reg [NC];
    logic [DOTW-1:0] dmid_reg [NC];
    logic [SLW-1:0]  clo_reg [NC];
    logic [SHW-1:0]  chi_reg [NC];
    logic [DOTW-1:0] cmid_reg [NC];
    logic [DSW-1:0]  r_sq_w;
    logic [DSW-1:0]  r_sq4_w;
    logic [DOTW-1:0] dot_mag [NC];
    logic [DOTW-1:0] crs_mag [NC];

    assign r_sq_w  = DSW'(r_sq_reg);
    assign r_sq4_w = DSW'({r_sq_reg, 2'b00});

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            dot_mag[k] = dot_reg[k][DOTW-1] ? DOTW'(-dot_reg[k]) : DOTW'(dot_reg[k]);
            crs_mag[k] = crs_reg[k][DOTW-1] ? DOTW'(-crs_reg[k]) : DOTW'(crs_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_hit_reg <= (DSW'(asq_reg) <= r_sq_w);
            for (int k = 0; k < NC; k++)
            begin
                c_hit_reg[k] <= (DSW'(csq_reg[k]) <= r_sq_w);
                g_hit_reg[k] <= (DSW'(gsq_reg[k]) <= r_sq4_w);
                dneg_reg[k]  <= dot_reg[k][DOTW-1];
                dlo_reg[k]   <= SLW'(dot_mag[k][HB-1:0]) * SLW'(dot_mag[k][HB-1:0]);
                dhi_reg[k]   <= SHW'(dot_mag[k][DOTW-1:HB]) * SHW'(dot_mag[k][DOTW-1:HB]);
                dmid_reg[k]  <= DOTW'(dot_mag[k][DOTW-1:HB]) * DOTW'(dot_mag[k][HB-1:0]);
                clo_reg[k]   <= SLW'(crs_mag[k][HB-1:0]) * SLW'(crs_mag[k][HB-1:0]);
                chi_reg[k]   <= SHW'(crs_mag[k][DOTW-1:HB]) * SHW'(crs_mag[k][DOTW-1:HB]);
                cmid_reg[k]  <= DOTW'(crs_mag[k][DOTW-1:HB]) * DOTW'(crs_mag[k][HB-1:0]);
            end
        end
    end

    // stage 5: assemble the squared rotate terms
    logic            a_hit5_reg;
    logic [NC-1:0]   c_hit5_reg;
    logic [NC-1:0]   g_hit5_reg;
    logic [NC-1:0]   dneg5_reg;
    logic [CMPW-1:0] dot_sq_reg [NC];
    logic [CMPW-1:0] crs_sq_reg [NC];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_hit5_reg <= a_hit_reg;
            c_hit5_reg <= c_hit_reg;
            g_hit5_reg <= g_hit_reg;
            dneg5_reg  <= dneg_reg;
            for (int k = 0; k < NC; k++)
            begin
                dot_sq_reg[k] <= (CMPW'(dhi_reg[k]) << SLW)
                               + (CMPW'(dmid_reg[k]) << (HB + 1))
                               + CMPW'(dlo_reg[k]);
                crs_sq_reg[k] <= (CMPW'(chi_reg[k]) << SLW)
                               + (CMPW'(cmid_reg[k]) << (HB + 1))
                               + CMPW'(clo_reg[k]);
            end
        end
    end

    // stage 6: rotate band compares and priority pick
    logic [NC-1:0]         r_hit;
    shht_pkg::handle_kind_t kind_next;
    shht_pkg::handle_kind_t kind_reg;

    // a corner on the centre never hits its rotate zone
    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            r_hit[k] = !dz_reg[k] && !dneg5_reg[k]
                     && (dot_sq_reg[k] >= in_rhs_reg[k])
                     && (dot_sq_reg[k] <= out_rhs_reg[k])
                     && (crs_sq_reg[k] <= r_rhs_reg[k]);
        end
    end

    always_comb
    begin
        kind_next = shht_pkg::KIND_NONE;
        for (int k = NC - 1; k >= 0; k--)
        begin
            if (r_hit[k])
            begin
                kind_next = shht_pkg::KIND_ROTATE + 4'(k);
            end
        end
        for (int k = NC - 1; k >= 0; k--)
        begin
            if (g_hit5_reg[k])
            begin
                kind_next = shht_pkg::KIND_EDGE + 4'(k);
            end
        end
        for (int k = NC - 1; k >= 0; k--)
        begin
            if (c_hit5_reg[k])
            begin
                kind_next = shht_pkg::KIND_CORNER + 4'(k);
            end
        end
        if (a_hit5_reg)
        begin
            kind_next = shht_pkg::KIND_ANCHOR;
        end
        if (!box_valid_reg)
        begin
            kind_next = shht_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= kind_next;
        end
    end

    assign handle_kind = kind_reg;

endmodule

// ----- test/tb_selection_handle_hit_test_unit.sv -----
// ----------------------------------------------------------------------------
// tb_selection_handle_hit_test_unit
// Drives query points through the hit test unit over several box settings,
// predicts each handle kind in exact integer arithmetic and checks the
// results in order, with random idling on both sides and a long result stall.
// ----------------------------------------------------------------------------
module tb_selection_handle_hit_test_unit;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_ready;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        result_valid;
    logic        result_ready;
    logic [3:0]  handle_kind;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // box registers as the predictor sees them
    logic        box_valid;
    logic [31:0] corner_reg [4];
    logic [31:0] anchor_reg;
    logic [15:0] radius_reg;
    logic [31:0] band_reg;

    point_t                 pending_points [$];
    shht_pkg::handle_kind_t expected_kinds [$];
    int  mismatches;
    int  results_seen;
    int  cycles;
    bit  calm;
    bit  hold_results;
    int  hold_cycles;
    logic point_taken;

    selection_handle_hit_test_unit dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready),
        .point_x(point_x), .point_y(point_y),
        .result_valid(result_valid), .result_ready(result_ready),
        .handle_kind(handle_kind),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // sign-extended coordinate at twice the Q12.4 scale
    function automatic longint twice(input logic [15:0] v);
        return 2 * longint'($signed(v));
    endfunction

    function automatic bit within_disc(input longint dx, input longint dy,
                                       input longint rsq);
        return dx * dx + dy * dy <= rsq;
    endfunction

    // handle classification for one point
    function automatic shht_pkg::handle_kind_t classify(input point_t p);
        longint px, py, ax, ay, r2, rsq, inner2, outer2, mx, my;
        longint cx [4];
        longint cy [4];
        longint dx, dy, ex, ey, dotp, crs;
        logic [127:0] len2, dsq, csq, lo, hi, rq;
        int n;
        if (!box_valid)
            return shht_pkg::KIND_NONE;
        px = twice(p.x);
        py = twice(p.y);
        for (int k = 0; k < 4; k++)
        begin
            cx[k] = twice(corner_reg[k][15:0]);
            cy[k] = twice(corner_reg[k][31:16]);
        end
        ax = twice(anchor_reg[15:0]);
        ay = twice(anchor_reg[31:16]);
        r2 = 2 * longint'(radius_reg);
        rsq = r2 * r2;
        if (within_disc(px - ax, py - ay, rsq))
            return shht_pkg::KIND_ANCHOR;
        for (int k = 0; k < 4; k++)
            if (within_disc(px - cx[k], py - cy[k], rsq))
                return shht_pkg::KIND_CORNER + shht_pkg::handle_kind_t'(k);
        for (int k = 0; k < 4; k++)
        begin
            n = (k + 1) % 4;
            if (within_disc(2 * px - cx[k] - cx[n], 2 * py - cy[k] - cy[n], 4 * rsq))
                return shht_pkg::KIND_EDGE + shht_pkg::handle_kind_t'(k);
        end
        inner2 = 2 * longint'(band_reg[15:0]);
        outer2 = 2 * longint'(band_reg[31:16]);
        if (outer2 < inner2)
            outer2 = inner2;
        mx = cx[0] + cx[2];
        my = cy[0] + cy[2];
        for (int k = 0; k < 4; k++)
        begin
            dx = 2 * cx[k] - mx;
            dy = 2 * cy[k] - my;
            ex = px - cx[k];
            ey = py - cy[k];
            if (dx == 0 && dy == 0)
            begin
                // corner on the centre: zone is a plain disc when inner is zero
                if (inner2 == 0 && ex * ex + ey * ey <= rsq)
                    return shht_pkg::KIND_ROTATE + shht_pkg::handle_kind_t'(k);
                continue;
            end
            len2 = 128'(dx * dx + dy * dy);
            dotp = ex * dx + ey * dy;
            if (dotp < 0)
                continue;
            dsq = 128'(dotp) * 128'(dotp);
            lo = 128'(inner2 * inner2) * len2;
            hi = 128'(outer2 * outer2) * len2;
            if (dsq < lo || dsq > hi)
                continue;
            crs = ex * dy - ey * dx;
            if (crs < 0)
                crs = -crs;
            csq = 128'(crs) * 128'(crs);
            rq = 128'(rsq) * len2;
            if (csq <= rq)
                return shht_pkg::KIND_ROTATE + shht_pkg::handle_kind_t'(k);
        end
        return shht_pkg::KIND_NONE;
    endfunction

    // apb write, setup then access
    task automatic write_reg(input shht_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            shht_pkg::REG_BOX_VALID:   box_valid = value[0];
            shht_pkg::REG_CORNER_0:    corner_reg[0] = value;
            shht_pkg::REG_CORNER_1:    corner_reg[1] = value;
            shht_pkg::REG_CORNER_2:    corner_reg[2] = value;
            shht_pkg::REG_CORNER_3:    corner_reg[3] = value;
            shht_pkg::REG_ANCHOR:      anchor_reg = value;
            shht_pkg::REG_HIT_RADIUS:  radius_reg = value[15:0];
            default:                   band_reg = value;
        endcase
    endtask

    task automatic load_box(input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] c3,
                            input logic [31:0] anc, input logic [15:0] rad,
                            input logic [31:0] band);
        write_reg(shht_pkg::REG_CORNER_0, c0);
        write_reg(shht_pkg::REG_CORNER_1, c1);
        write_reg(shht_pkg::REG_CORNER_2, c2);
        write_reg(shht_pkg::REG_CORNER_3, c3);
        write_reg(shht_pkg::REG_ANCHOR, anc);
        write_reg(shht_pkg::REG_HIT_RADIUS, {16'd0, rad});
        write_reg(shht_pkg::REG_ROTATE_BAND, band);
    endtask

    // queue a point and its expected kind
    task automatic send_point(input logic [15:0] x, input logic [15:0] y);
        point_t p;
        p.x = x;
        p.y = y;
        pending_points = {pending_points, p};
        expected_kinds = {expected_kinds, classify(p)};
    endtask

    task automatic drain;
        while (pending_points.size() != 0 || expected_kinds.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [15:0] near_coord(input logic [15:0] base);
        return base + 16'($urandom_range(0, 160)) - 16'd80;
    endfunction

    // random points, mostly close to handles of the box
    task automatic random_points(input int count);
        logic [31:0] t;
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1: send_point(16'($urandom), 16'($urandom));
                2: t = anchor_reg;
                3, 4: t = corner_reg[$urandom_range(0, 3)];
                5, 6:
                begin
                    int k = $urandom_range(0, 3);
                    t[15:0]  = 16'(($signed(corner_reg[k][15:0]) +
                                     $signed(corner_reg[(k + 1) % 4][15:0])) >>> 1);
                    t[31:16] = 16'(($signed(corner_reg[k][31:16]) +
                                     $signed(corner_reg[(k + 1) % 4][31:16])) >>> 1);
                end
                default:
                begin
                    // beyond a corner, out from the centre
                    int k = $urandom_range(0, 3);
                    t[15:0]  = 16'(2 * $signed(corner_reg[k][15:0]) -
                                   $signed(corner_reg[(k + 2) % 4][15:0]) / 2 -
                                   $signed(corner_reg[k][15:0]) / 2);
                    t[31:16] = 16'(2 * $signed(corner_reg[k][31:16]) -
                                   $signed(corner_reg[(k + 2) % 4][31:16]) / 2 -
                                   $signed(corner_reg[k][31:16]) / 2);
                end
            endcase
            if (sel >= 2)
                send_point(near_coord(t[15:0]), near_coord(t[31:16]));
        end
    endtask

    // point acceptance, sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_taken <= 1'b0;
        else
        begin
            point_taken <= point_valid && point_ready;
            if (point_valid && point_ready)
                void'(pending_points.pop_front());
        end
    end

    // point driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
            point_x     <= '0;
            point_y     <= '0;
        end
        else if (!point_valid || point_taken)
        begin
            // previous request taken (or none pending): pick up the next
            if (pending_points.size() > 0 &&
                (calm || $urandom_range(0, 99) >= 17))
            begin
                point_valid <= 1'b1;
                point_x     <= pending_points[0].x;
                point_y     <= pending_points[0].y;
            end
            else
                point_valid <= 1'b0;
        end
    end

    // result stall pattern
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_results)
        begin
            result_ready <= 1'b0;
            hold_cycles  <= hold_cycles + 1;
        end
        else
            result_ready <= calm || $urandom_range(0, 99) >= 17;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_kinds.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result kind %0d", handle_kind);
            end
            else if (handle_kind !== expected_kinds[0])
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("kind mismatch: expected %0d, got %0d",
                             expected_kinds[0], handle_kind);
                void'(expected_kinds.pop_front());
            end
            else
                void'(expected_kinds.pop_front());
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        results_seen = 0;
        cycles = 0;
        calm = 1'b0;
        hold_results = 1'b0;
        hold_cycles = 0;
        box_valid = 1'b0;
        for (int k = 0; k < 4; k++)
            corner_reg[k] = '0;
        anchor_reg = '0;
        radius_reg = '0;
        band_reg = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // box not loaded: everything is none
        send_point(16'h0000, 16'h0000);
        send_point(16'h7fff, 16'h8000);
        drain();

        // axis-aligned box, radius 4, rotate band 8..24
        load_box({16'hff00, 16'hff00}, {16'hff00, 16'h0100}, {16'h0100, 16'h0100},
                 {16'h0100, 16'hff00}, {16'h0020, 16'h0030}, 16'h0040,
                 {16'h0180, 16'h0080});
        write_reg(shht_pkg::REG_BOX_VALID, 32'd1);
        send_point(16'h0030, 16'h0020);   // anchor
        send_point(16'hff00, 16'hff00);   // corner 0
        send_point(16'h0100, 16'hff10);   // corner 1
        send_point(16'h0100, 16'h0100);   // corner 2
        send_point(16'hff00, 16'h0100);   // corner 3
        send_point(16'h0000, 16'hff00);   // edge 0
        send_point(16'h0100, 16'h0000);   // edge 1
        send_point(16'h0000, 16'h0100);   // edge 2
        send_point(16'hff00, 16'h0000);   // edge 3
        send_point(16'hfe80, 16'hfe80);   // rotate 0
        send_point(16'h0180, 16'hfe80);   // rotate 1
        send_point(16'h0180, 16'h0180);   // rotate 2
        send_point(16'hfe80, 16'h0180);   // rotate 3
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h8000);
        send_point(16'h8000, 16'h7fff);
        send_point(16'h5555, 16'haaaa);
        send_point(16'haaaa, 16'h5555);
        drain();

        // outer below inner, and degenerate box with corners on the centre
        write_reg(shht_pkg::REG_ROTATE_BAND, {16'h0010, 16'h0090});
        send_point(16'hfe00, 16'hfe00);
        send_point(16'hfe70, 16'hfe70);
        drain();
        load_box(32'h0, 32'h0, 32'h0, 32'h0, {16'h7fff, 16'h7fff}, 16'h0010, 32'h0);
        send_point(16'h0008, 16'h0004);
        send_point(16'h0030, 16'h0000);
        drain();

        // random box settings, extremes among them
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_box(32'h8000_8000, 32'h8000_7fff, 32'h7fff_7fff,
                            32'h7fff_8000, 32'h0, 16'hffff, 32'hffff_ffff);
                1: load_box(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                            32'hffff_ffff, 32'hffff_ffff, 16'h0000, 32'h0000_ffff);
                default:
                begin
                    logic [15:0] s;
                    s = 16'($urandom_range(16, 2000));
                    load_box({-s, -s + 16'($urandom_range(0, 64))}, {-s, s},
                             {s, s}, {s, -s}, {16'($urandom), 16'($urandom)},
                             16'($urandom_range(4, 200)),
                             {16'($urandom_range(0, 800)), 16'($urandom_range(0, 400))});
                end
            endcase
            if (ph == 5)
                write_reg(shht_pkg::REG_BOX_VALID, 32'd0);
            if (ph == 6)
                write_reg(shht_pkg::REG_BOX_VALID, 32'd1);
            if (ph == 3)
            begin
                // no idling at all, then a long result stall while points queue
                calm = 1'b1;
                random_points(40);
                repeat (5) @(posedge clk);
                hold_results = 1'b1;
                wait (hold_cycles >= 60);
                hold_results = 1'b0;
                random_points(40);
                calm = 1'b0;
            end
            else
                random_points(80);
            // sender pauses until every result has come
            drain();
        end

        $display("checked %0d results over directed cases and eight box settings,",
                 results_seen);
        $display("including a full-range box, a degenerate box and a long result stall");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
